// ===== design/occ_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occurrence checkpoint counter package
// Shared widths, symbol codes, queue entry and status types.
// ----------------------------------------------------------------------------
package occ_pkg;

   localparam int CountWidth   = 32;
   localparam int OutWidth     = 32;
   localparam int NumSymbols   = 6;
   localparam int LengthWidth  = 6;
   localparam int ByteWidth    = 8;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   localparam int SlotA   = 0;
   localparam int SlotC   = 1;
   localparam int SlotG   = 2;
   localparam int SlotT   = 3;
   localparam int SlotN   = 4;
   localparam int SlotEnd = 5;

   localparam logic [ByteWidth-1:0] CodeA   = 8'h41;
   localparam logic [ByteWidth-1:0] CodeC   = 8'h43;
   localparam logic [ByteWidth-1:0] CodeG   = 8'h47;
   localparam logic [ByteWidth-1:0] CodeT   = 8'h54;
   localparam logic [ByteWidth-1:0] CodeN   = 8'h4E;
   localparam logic [ByteWidth-1:0] CodeEnd = 8'h24;

   localparam logic [LengthWidth-1:0] ChunkLengthReset = LengthWidth'(16);

   typedef logic [CountWidth-1:0]                  count_type;
   typedef logic [NumSymbols-1:0][CountWidth-1:0]  count_vec_type;
   typedef logic [NumSymbols-1:0]                  slot_type;
   typedef logic [LengthWidth-1:0]                 length_type;

   typedef struct packed {
      slot_type slot;
      logic     emit;
      logic     last;
   } entry_type;

   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QueueCntWidth-1:0] count;
   } queue_status_type;

   function automatic slot_type symbol_slot(input logic [ByteWidth-1:0] code);
      slot_type s;
      s = '0;
      unique case (code)
         CodeA:   s[SlotA]   = 1'b1;
         CodeC:   s[SlotC]   = 1'b1;
         CodeG:   s[SlotG]   = 1'b1;
         CodeT:   s[SlotT]   = 1'b1;
         CodeN:   s[SlotN]   = 1'b1;
         CodeEnd: s[SlotEnd] = 1'b1;
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

// ===== design/occ_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occurrence checkpoint front end
// Accepts symbol beats, decodes the symbol and decides where chunks close.
// ----------------------------------------------------------------------------
module occ_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [occ_pkg::ByteWidth-1:0]  req_symbol_byte,
   input  logic                           req_last_symbol,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  occ_pkg::length_type            csr_chunk_length,
   input  occ_pkg::queue_status_type      q_status,
   output logic                           push,
   output occ_pkg::entry_type             push_entry
);
   import occ_pkg::*;

   length_type                chunk_length_ff, chunk_length_in;
   logic [LengthWidth-1:0]    position_ff, position_in;
   logic [LengthWidth:0]      position_next;
   length_type                eff_length;
   logic                      emit;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      eff_length    = (chunk_length_ff == '0) ? LengthWidth'(1) : chunk_length_ff;
      position_next = {1'b0, position_ff} + (LengthWidth+1)'(1);
      emit          = req_last_symbol || (position_next >= {1'b0, eff_length});

      push_entry.slot = symbol_slot(req_symbol_byte);
      push_entry.emit = emit;
      push_entry.last = req_last_symbol;

      chunk_length_in = (csr_valid && csr_ready) ? csr_chunk_length : chunk_length_ff;
      position_in     = position_ff;
      if (push) begin
         position_in = emit ? '0 : position_next[LengthWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_length_ff <= ChunkLengthReset;
         position_ff     <= '0;
      end else begin
         chunk_length_ff <= chunk_length_in;
         position_ff     <= position_in;
      end
   end

endmodule

// ===== design/occ_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occurrence checkpoint queue
// Short FIFO of decoded beats between the front end and the counters.
// ----------------------------------------------------------------------------
module occ_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  occ_pkg::entry_type         push_entry,
   input  logic                       pop,
   output occ_pkg::entry_type         pop_entry,
   output occ_pkg::queue_status_type  status
);
   import occ_pkg::*;

   entry_type                 mem_ff [QueueDepth];
   logic [QueuePtrWidth-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrWidth-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QueueCntWidth-1:0]  count_ff, count_in;

   always_comb begin
      status.count = count_ff;
      status.full  = (count_ff == QueueCntWidth'(QueueDepth));
      status.empty = (count_ff == '0);
      pop_entry    = mem_ff[rd_ptr_ff];

      wr_ptr_in = push ? wr_ptr_ff + QueuePtrWidth'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QueuePtrWidth'(1) : rd_ptr_ff;
      count_in  = count_ff + QueueCntWidth'(push) - QueueCntWidth'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== design/occ_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Occurrence checkpoint back end
// Keeps the six saturating counts and registers checkpoint rows.
// ----------------------------------------------------------------------------
module occ_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   input  occ_pkg::entry_type     q_entry,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output occ_pkg::count_vec_type rsp_counts,
   output logic                   rsp_final_row
);
   import occ_pkg::*;

   count_vec_type  counts_ff, counts_in, counts_next;
   count_vec_type  row_ff, row_in;
   logic           final_ff, final_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;
   logic           load;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      pop      = q_valid && (!q_entry.emit || out_free);
      load     = pop && q_entry.emit;

      for (int k = 0; k < NumSymbols; k++) begin
         if (q_entry.slot[k] && (counts_ff[k] != '1)) begin
            counts_next[k] = counts_ff[k] + CountWidth'(1);
         end else begin
            counts_next[k] = counts_ff[k];
         end
      end

      counts_in = counts_ff;
      if (pop) begin
         counts_in = q_entry.last ? '0 : counts_next;
      end

      row_in       = load ? counts_next : row_ff;
      final_in     = load ? q_entry.last : final_ff;
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         counts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         counts_ff    <= counts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      final_ff <= final_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_counts    = row_ff;
   assign rsp_final_row = final_ff;

endmodule

// ===== design/occurrence_checkpoint_counter.sv =====
`timescale 1ns / 1ps
// A closing beat enters the queue, then is loaded into the rsp row register.
// Throughput: one symbol beat per cycle; beats back up in the four-entry queue
// only while a closing beat waits behind a row that a stalled rsp still holds.
// Reset clears the counts, chunk position, queue and rsp_valid, and sets the
// chunk length to 16.
// ----------------------------------------------------------------------------
// Occurrence checkpoint counter
// Counts A, C, G, T, N and $ symbols and emits cumulative checkpoint rows.
// ----------------------------------------------------------------------------
module occurrence_checkpoint_counter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [occ_pkg::ByteWidth-1:0]  req_symbol_byte,
   input  logic                           req_last_symbol,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_a,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_c,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_g,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_t,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_n,
   output logic [occ_pkg::OutWidth-1:0]   rsp_count_end_marker,
   output logic                           rsp_final_row,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [occ_pkg::LengthWidth-1:0] csr_chunk_length
);
   import occ_pkg::*;

   logic             push;
   entry_type        push_entry;
   logic             pop;
   entry_type        pop_entry;
   queue_status_type q_status;
   count_vec_type    rsp_counts;

   occ_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_symbol_byte  (req_symbol_byte),
      .req_last_symbol  (req_last_symbol),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_chunk_length (csr_chunk_length),
      .q_status         (q_status),
      .push             (push),
      .push_entry       (push_entry)
   );

   occ_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .status     (q_status)
   );

   occ_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (!q_status.empty),
      .q_entry       (pop_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_counts    (rsp_counts),
      .rsp_final_row (rsp_final_row)
   );

   assign rsp_count_a          = rsp_counts[SlotA][OutWidth-1:0];
   assign rsp_count_c          = rsp_counts[SlotC][OutWidth-1:0];
   assign rsp_count_g          = rsp_counts[SlotG][OutWidth-1:0];
   assign rsp_count_t          = rsp_counts[SlotT][OutWidth-1:0];
   assign rsp_count_n          = rsp_counts[SlotN][OutWidth-1:0];
   assign rsp_count_end_marker = rsp_counts[SlotEnd][OutWidth-1:0];

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QueueCntWidth'(QueueDepth))
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (q_status.count == $past(q_status.count) + QueueCntWidth'(1)))
      else $error("queue count did not advance on push");

endmodule
